### sv/x86tbc_pkg.sv
// shared types, codes and tables for the two-byte opcode classifier
package x86tbc_pkg;

  // mnemonic codes, dense by order of first use
  typedef enum logic [6:0] {
    M_NONE, M_SLDT, M_STR, M_LLDT, M_LTR, M_VERR, M_VERW, M_ENCLV, M_VMCALL,
    M_VMLAUNCH, M_VMRESUME, M_VMXOFF, M_PCONFIG, M_SGDT, M_MONITOR, M_MWAIT,
    M_SIDT, M_XGETBV, M_XSETBV, M_VMFUNC, M_XEND, M_XTEST, M_ENCLU, M_LGDT,
    M_VMRUN, M_VMMCALL, M_VMLOAD, M_VMSAVE, M_STGI, M_CLGI, M_SKINIT,
    M_INVLPGA, M_LIDT, M_SMSW, M_LMSW, M_SWAPGS, M_RDTSCP, M_INVLPG, M_LAR,
    M_LSL, M_SYSCALL, M_CLTS, M_SYSRET, M_INVD, M_WBINVD, M_UD2, M_NOP,
    M_PREFETCH, M_PREFETCHW, M_PREFETCHWT1, M_MOVSS, M_MOVSD, M_MOVUPD,
    M_MOVUPS, M_MOVSLDUP, M_MOVDDUP, M_MOVLPD, M_MOVHLPS, M_MOVLPS,
    M_UNPCKLPD, M_UNPCKLPS, M_UNPCKHPD, M_UNPCKHPS, M_MOVSHDUP, M_MOVHPD,
    M_MOVLHPS, M_MOVHPS, M_PREFETCHNTA, M_PREFETCHT0, M_PREFETCHT1,
    M_PREFETCHT2, M_CMOV_BASE
  } mnem_t;

  localparam logic [6:0] SET_BASE = 7'(M_CMOV_BASE) + 7'd16;

  // operand form codes
  typedef enum logic [4:0] {
    F_NONE, F_M16R, F_RM16, F_M, F_M8, F_ECX, F_EDX, F_EAX, F_R163264,
    F_M1632, F_XMM, F_XMM32, F_XMM64, F_XMM128, F_M64, F_RM1632,
    F_RM163264, F_RM8
  } form_t;

  // opcode bytes with special handling
  localparam logic [7:0] OP_GRP0   = 8'h00;
  localparam logic [7:0] OP_GRP1   = 8'h01;
  localparam logic [7:0] OP_LAR    = 8'h02;
  localparam logic [7:0] OP_LSL    = 8'h03;
  localparam logic [7:0] OP_UD2    = 8'h0b;
  localparam logic [7:0] OP_PFW    = 8'h0D;
  localparam logic [7:0] OP_MOVU_L = 8'h10;
  localparam logic [7:0] OP_MOVU_S = 8'h11;
  localparam logic [7:0] OP_MOVL_L = 8'h12;
  localparam logic [7:0] OP_MOVL_S = 8'h13;
  localparam logic [7:0] OP_UNPL   = 8'h14;
  localparam logic [7:0] OP_UNPH   = 8'h15;
  localparam logic [7:0] OP_MOVH_L = 8'h16;
  localparam logic [7:0] OP_MOVH_S = 8'h17;
  localparam logic [7:0] OP_HINT   = 8'h18;
  localparam logic [3:0] HI_CMOV   = 4'h4;
  localparam logic [3:0] HI_SET    = 4'h9;
  localparam logic [1:0] MOD_REG   = 2'd3;

  // input word after registering
  typedef struct packed {
    logic [7:0] opcode_byte;
    logic [7:0] modrm_byte;
    logic       has_rep;
    logic       has_repne;
    logic       has_opsize;
    logic [3:0] prefix_count;
  } item_t;

  // classification result
  typedef struct packed {
    logic       valid_res;
    logic [6:0] mnemonic;
    logic [1:0] operand_count;
    logic [4:0] operand_form_a;
    logic [4:0] operand_form_b;
    logic [4:0] operand_form_c;
    logic [4:0] direct_length;
    logic       modrm_tail;
  } result_t;

  // 0F 01 register forms, indexed by reg then rm
  function automatic mnem_t grp1_reg(input logic [2:0] reg_f, input logic [2:0] rm_f);
    mnem_t m;
    m = M_NONE;
    case (reg_f)
      3'd0: case (rm_f)
        3'd0: m = M_ENCLV;    3'd1: m = M_VMCALL;
        3'd2: m = M_VMLAUNCH; 3'd3: m = M_VMRESUME;
        3'd4: m = M_VMXOFF;   3'd5: m = M_PCONFIG;
        default: m = M_NONE;
      endcase
      3'd2: case (rm_f)
        3'd0: m = M_XGETBV; 3'd1: m = M_XSETBV;
        3'd4: m = M_VMFUNC; 3'd5: m = M_XEND;
        3'd6: m = M_XTEST;  3'd7: m = M_ENCLU;
        default: m = M_NONE;
      endcase
      3'd3: case (rm_f)
        3'd0: m = M_VMRUN; 3'd1: m = M_VMMCALL;
        3'd2: m = M_VMLOAD; 3'd3: m = M_VMSAVE;
        3'd4: m = M_STGI;  3'd5: m = M_CLGI;
        3'd6: m = M_SKINIT; default: m = M_INVLPGA;
      endcase
      3'd7: case (rm_f)
        3'd0: m = M_SWAPGS; 3'd1: m = M_RDTSCP;
        default: m = M_NONE;
      endcase
      default: m = M_NONE;
    endcase
    return m;
  endfunction

endpackage

### sv/x86tbc_decode.sv
// combinational classification of one registered opcode word
module x86tbc_decode
  import x86tbc_pkg::*;
(
  input  item_t   item,
  output result_t res
);

  logic [1:0] mod_f;
  logic [2:0] reg_f;
  logic [2:0] rm_f;
  logic [4:0] lt;
  logic [4:0] l3;
  mnem_t      mn;
  form_t      f;

  assign mod_f = item.modrm_byte[7:6];
  assign reg_f = item.modrm_byte[5:3];
  assign rm_f  = item.modrm_byte[2:0];
  assign lt    = 5'd2 + 5'(item.prefix_count);
  assign l3    = 5'd3 + 5'(item.prefix_count);

  // fill the result fields
  function automatic result_t mk(input mnem_t m, input logic [1:0] n, input form_t a,
                                 input form_t b, input form_t c, input logic [4:0] len,
                                 input logic tail);
    result_t r;
    r.valid_res      = (m != M_NONE);
    r.mnemonic       = 7'(m);
    r.operand_count  = n;
    r.operand_form_a = 5'(a);
    r.operand_form_b = 5'(b);
    r.operand_form_c = 5'(c);
    r.direct_length  = len;
    r.modrm_tail     = tail;
    return r;
  endfunction

  // opcode decode
  always_comb begin
    res = mk(M_NONE, 2'd0, F_NONE, F_NONE, F_NONE, 5'd2, 1'b0);
    mn  = M_NONE;
    f   = F_NONE;
    unique case (item.opcode_byte) inside
      OP_GRP0: begin
        case (reg_f)
          3'd0: mn = M_SLDT; 3'd1: mn = M_STR; 3'd2: mn = M_LLDT;
          3'd3: mn = M_LTR;  3'd4: mn = M_VERR; 3'd5: mn = M_VERW;
          default: mn = M_NONE;
        endcase
        if (mn != M_NONE)
          res = mk(mn, 2'd1, (reg_f < 3'd2) ? F_M16R : F_RM16, F_NONE, F_NONE, lt, 1'b1);
      end
      OP_GRP1: begin
        if (reg_f == 3'd4) begin
          res = mk(M_SMSW, 2'd1, F_M16R, F_NONE, F_NONE, lt, 1'b1);
        end else if (reg_f == 3'd6) begin
          res = mk(M_LMSW, 2'd1, F_RM16, F_NONE, F_NONE, lt, 1'b1);
        end else if (mod_f != MOD_REG) begin
          case (reg_f)
            3'd0: mn = M_SGDT; 3'd1: mn = M_SIDT; 3'd2: mn = M_LGDT;
            3'd3: mn = M_LIDT; 3'd7: mn = M_INVLPG;
            default: mn = M_NONE;
          endcase
          if (mn != M_NONE) res = mk(mn, 2'd1, F_M, F_NONE, F_NONE, lt, 1'b1);
        end else if (reg_f == 3'd1) begin
          if (rm_f == 3'd0)
            res = mk(M_MONITOR, 2'd3, F_M8, F_ECX, F_EDX, lt, 1'b1);
          else if (rm_f == 3'd1)
            res = mk(M_MWAIT, 2'd2, F_EAX, F_ECX, F_NONE, l3, 1'b0);
        end else begin
          mn = grp1_reg(reg_f, rm_f);
          if (mn != M_NONE) res = mk(mn, 2'd0, F_NONE, F_NONE, F_NONE, l3, 1'b0);
        end
      end
      OP_LAR, OP_LSL:
        res = mk((item.opcode_byte == OP_LAR) ? M_LAR : M_LSL, 2'd2, F_R163264, F_M16R,
                 F_NONE, lt, 1'b1);
      [8'h05:8'h09]: begin
        case (item.opcode_byte[3:0])
          4'h5: mn = M_SYSCALL; 4'h6: mn = M_CLTS; 4'h7: mn = M_SYSRET;
          4'h8: mn = M_INVD; default: mn = M_WBINVD;
        endcase
        res = mk(mn, 2'd0, F_NONE, F_NONE, F_NONE, lt, 1'b0);
      end
      OP_UD2: res = mk(M_UD2, 2'd0, F_NONE, F_NONE, F_NONE, lt, 1'b0);
      OP_PFW: begin
        if (mod_f == MOD_REG) begin
          res = mk(M_NOP, 2'd0, F_NONE, F_NONE, F_NONE, l3, 1'b0);
        end else begin
          case (reg_f)
            3'd0: mn = M_PREFETCH; 3'd1: mn = M_PREFETCHW; 3'd2: mn = M_PREFETCHWT1;
            default: mn = M_NOP;
          endcase
          res = mk(mn, 2'd1, F_M1632, F_NONE, F_NONE, lt, 1'b1);
        end
      end
      OP_MOVU_L, OP_MOVU_S: begin
        if (item.has_rep)         begin mn = M_MOVSS;  f = F_XMM32;  end
        else if (item.has_repne)  begin mn = M_MOVSD;  f = F_XMM64;  end
        else if (item.has_opsize) begin mn = M_MOVUPD; f = F_XMM128; end
        else                      begin mn = M_MOVUPS; f = F_XMM128; end
        if (item.opcode_byte == OP_MOVU_L)
          res = mk(mn, 2'd2, F_XMM, f, F_NONE, lt, 1'b1);
        else
          res = mk(mn, 2'd2, f, F_XMM, F_NONE, lt, 1'b1);
      end
      OP_MOVL_L: begin
        if (item.has_rep)         res = mk(M_MOVSLDUP, 2'd2, F_XMM, F_XMM64, F_NONE, lt, 1'b1);
        else if (item.has_repne)  res = mk(M_MOVDDUP, 2'd2, F_XMM, F_XMM64, F_NONE, lt, 1'b1);
        else if (item.has_opsize) res = mk(M_MOVLPD, 2'd2, F_XMM, F_M64, F_NONE, lt, 1'b1);
        else res = mk((mod_f == MOD_REG) ? M_MOVHLPS : M_MOVLPS, 2'd2, F_XMM, F_XMM64,
                      F_NONE, lt, 1'b1);
      end
      OP_MOVL_S:
        res = mk(item.has_opsize ? M_MOVLPD : M_MOVLPS, 2'd2, F_M64, F_XMM, F_NONE, lt, 1'b1);
      OP_UNPL: begin
        if (item.has_opsize) res = mk(M_UNPCKLPD, 2'd2, F_XMM, F_XMM64, F_NONE, lt, 1'b1);
        else res = mk(M_UNPCKLPS, 2'd2, F_XMM, F_XMM128, F_NONE, lt, 1'b1);
      end
      OP_UNPH: begin
        if (item.has_opsize) res = mk(M_UNPCKHPD, 2'd2, F_XMM, F_XMM64, F_NONE, lt, 1'b1);
        else res = mk(M_UNPCKHPS, 2'd2, F_XMM, F_XMM128, F_NONE, lt, 1'b1);
      end
      OP_MOVH_L: begin
        if (item.has_rep)         res = mk(M_MOVSHDUP, 2'd2, F_XMM, F_XMM64, F_NONE, lt, 1'b1);
        else if (item.has_opsize) res = mk(M_MOVHPD, 2'd2, F_XMM, F_M64, F_NONE, lt, 1'b1);
        else res = mk((mod_f == MOD_REG) ? M_MOVLHPS : M_MOVHPS, 2'd2, F_XMM, F_XMM64,
                      F_NONE, lt, 1'b1);
      end
      OP_MOVH_S:
        res = mk(item.has_opsize ? M_MOVHPD : M_MOVHPS, 2'd2, F_M64, F_XMM, F_NONE, lt, 1'b1);
      OP_HINT: begin
        if (mod_f != MOD_REG && !reg_f[2])
          res = mk(mnem_t'(7'(M_PREFETCHNTA) + 7'(reg_f)), 2'd1, F_M8, F_NONE, F_NONE,
                   lt, 1'b1);
        else
          res = mk(M_NOP, 2'd1, F_RM1632, F_NONE, F_NONE, lt, 1'b1);
      end
      [8'h19:8'h1f]: res = mk(M_NOP, 2'd1, F_RM1632, F_NONE, F_NONE, lt, 1'b1);
      [8'h40:8'h4f]:
        res = mk(mnem_t'(7'(M_CMOV_BASE) + 7'(item.opcode_byte[3:0])), 2'd2, F_R163264,
                 F_RM163264, F_NONE, lt, 1'b1);
      [8'h90:8'h9f]:
        res = mk(mnem_t'(SET_BASE + 7'(item.opcode_byte[3:0])), 2'd1, F_RM8, F_NONE,
                 F_NONE, lt, 1'b1);
      default: res = mk(M_NONE, 2'd0, F_NONE, F_NONE, F_NONE, 5'd2, 1'b0);
    endcase
  end

endmodule

### sv/x86_two_byte_opcode_classify.sv
// top level: input register, classifier, result register
//
//  channel | dir | tdata fields (lsb first)                              | tuser
//  in_     | in  | opcode_byte, modrm_byte, has_rep, has_repne,          | -
//          |     | has_opsize, prefix_count (23 bits, padded to 24)      |
//  out_    | out | valid_res, mnemonic, operand_count, operand_form_a/b/c,| -
//          |     | direct_length, modrm_tail (31 bits, padded to 32)     |
//
// one word per cycle while the output is not stalled; the result is registered
// (input register, then result register after one level of decode logic).
// rst_n clears both valid flags; payload registers are not reset.
// a stalled output holds its word; the result stage loads whenever it is not
// stalled, the input stage whenever it is empty or its word moves on.
module x86_two_byte_opcode_classify
  import x86tbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode_byte, modrm_byte, has_rep, has_repne,
                                  // has_opsize, prefix_count, pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // valid_res, mnemonic, operand_count, operand_form_a,
                                  // operand_form_b, operand_form_c, direct_length,
                                  // modrm_tail, pad
);

  item_t   item_r, item_nxt;
  logic    ivld_r, ivld_nxt;
  result_t res_r, res_nxt;
  logic    ovld_r, ovld_nxt;
  result_t dec;
  logic    ostall;
  logic    iadv;

  // stage enables
  assign ostall    = ovld_r && !out_tready;
  assign iadv      = !(ivld_r && ostall);
  assign in_tready = iadv;

  // unpack the input word
  always_comb begin
    item_nxt.opcode_byte  = in_tdata[7:0];
    item_nxt.modrm_byte   = in_tdata[15:8];
    item_nxt.has_rep      = in_tdata[16];
    item_nxt.has_repne    = in_tdata[17];
    item_nxt.has_opsize   = in_tdata[18];
    item_nxt.prefix_count = in_tdata[22:19];
  end

  x86tbc_decode u_decode (
    .item (item_r),
    .res  (dec)
  );

  // valid flags
  always_comb begin
    ivld_nxt = iadv ? in_tvalid : ivld_r;
    ovld_nxt = ostall ? ovld_r : ivld_r;
    res_nxt  = dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      ivld_r <= ivld_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (iadv) item_r <= item_nxt;
    if (!ostall) res_r <= res_nxt;
  end

  // pack the output word
  assign out_tvalid = ovld_r;
  assign out_tdata  = {1'b0, res_r.modrm_tail, res_r.direct_length, res_r.operand_form_c,
                       res_r.operand_form_b, res_r.operand_form_a, res_r.operand_count,
                       res_r.mnemonic, res_r.valid_res};

  // a held output word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output word changed under stall");

  // valid flag agrees with a nonzero mnemonic
  a_vmn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r.valid_res == (res_r.mnemonic != 7'd0)))
    else $error("valid flag and mnemonic disagree");

  // invalid results carry the fixed length of two
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res_r.valid_res) |-> (res_r.direct_length == 5'd2 && !res_r.modrm_tail))
    else $error("invalid result has wrong length");

  // an accepted word reaches the result stage when it is free
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (ivld_r && !ostall) |=> ovld_r)
    else $error("word lost between stages");

endmodule

### test/x86tbc_checker.sv
// checker for the two-byte opcode classifier: predicts each result word and compares it
module x86tbc_checker
  import x86tbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode_byte, modrm_byte, has_rep, has_repne,
                                  // has_opsize, prefix_count, pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // valid_res, mnemonic, operand_count, forms a/b/c,
                                  // direct_length, modrm_tail, pad
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [6:0] mn;
    logic [1:0] cnt;
    logic [4:0] fa, fb, fc;
    logic [4:0] len;
    logic       tail;
  } cls_t;

  cls_t want_q[$];

  function automatic cls_t mk(logic [6:0] mn, int cnt, form_t a, form_t b, form_t c,
                              int len, bit tail);
    cls_t r;
    r.mn = mn; r.cnt = 2'(cnt); r.fa = a; r.fb = b; r.fc = c;
    r.len = 5'(len); r.tail = tail;
    return r;
  endfunction

  // classification of one opcode word
  function automatic cls_t classify(logic [23:0] w);
    logic [7:0] op, mrm;
    logic [1:0] md;
    logic [2:0] rg, rm;
    logic       rep, rnz, osz;
    int         lt, l3;
    mnem_t      m;
    form_t      f;
    cls_t       r;
    op = w[7:0]; mrm = w[15:8]; rep = w[16]; rnz = w[17]; osz = w[18];
    md = mrm[7:6]; rg = mrm[5:3]; rm = mrm[2:0];
    lt = 2 + w[22:19]; l3 = 3 + w[22:19];
    r = mk(M_NONE, 0, F_NONE, F_NONE, F_NONE, 2, 0);
    if (op == 8'h00) begin
      case (rg)
        3'd0: m = M_SLDT; 3'd1: m = M_STR; 3'd2: m = M_LLDT;
        3'd3: m = M_LTR; 3'd4: m = M_VERR; 3'd5: m = M_VERW;
        default: m = M_NONE;
      endcase
      if (m != M_NONE) r = mk(m, 1, rg < 2 ? F_M16R : F_RM16, F_NONE, F_NONE, lt, 1);
    end else if (op == 8'h01) begin
      if (rg == 4) r = mk(M_SMSW, 1, F_M16R, F_NONE, F_NONE, lt, 1);
      else if (rg == 6) r = mk(M_LMSW, 1, F_RM16, F_NONE, F_NONE, lt, 1);
      else if (md != 2'd3) begin
        case (rg)
          3'd0: m = M_SGDT; 3'd1: m = M_SIDT; 3'd2: m = M_LGDT;
          3'd3: m = M_LIDT; 3'd7: m = M_INVLPG;
          default: m = M_NONE;
        endcase
        if (m != M_NONE) r = mk(m, 1, F_M, F_NONE, F_NONE, lt, 1);
      end else if (rg == 1) begin
        if (rm == 0) r = mk(M_MONITOR, 3, F_M8, F_ECX, F_EDX, lt, 1);
        else if (rm == 1) r = mk(M_MWAIT, 2, F_EAX, F_ECX, F_NONE, l3, 0);
      end else begin
        m = M_NONE;
        case ({rg, rm})
          6'o00: m = M_ENCLV;   6'o01: m = M_VMCALL;  6'o02: m = M_VMLAUNCH;
          6'o03: m = M_VMRESUME; 6'o04: m = M_VMXOFF; 6'o05: m = M_PCONFIG;
          6'o20: m = M_XGETBV;  6'o21: m = M_XSETBV;  6'o24: m = M_VMFUNC;
          6'o25: m = M_XEND;    6'o26: m = M_XTEST;   6'o27: m = M_ENCLU;
          6'o30: m = M_VMRUN;   6'o31: m = M_VMMCALL; 6'o32: m = M_VMLOAD;
          6'o33: m = M_VMSAVE;  6'o34: m = M_STGI;    6'o35: m = M_CLGI;
          6'o36: m = M_SKINIT;  6'o37: m = M_INVLPGA;
          6'o70: m = M_SWAPGS;  6'o71: m = M_RDTSCP;
          default: m = M_NONE;
        endcase
        if (m != M_NONE) r = mk(m, 0, F_NONE, F_NONE, F_NONE, l3, 0);
      end
    end else if (op == 8'h02 || op == 8'h03) begin
      r = mk(op == 8'h02 ? M_LAR : M_LSL, 2, F_R163264, F_M16R, F_NONE, lt, 1);
    end else if (op >= 8'h05 && op <= 8'h09) begin
      case (op)
        8'h05: m = M_SYSCALL; 8'h06: m = M_CLTS; 8'h07: m = M_SYSRET;
        8'h08: m = M_INVD; default: m = M_WBINVD;
      endcase
      r = mk(m, 0, F_NONE, F_NONE, F_NONE, lt, 0);
    end else if (op == 8'h0b) begin
      r = mk(M_UD2, 0, F_NONE, F_NONE, F_NONE, lt, 0);
    end else if (op == 8'h0d) begin
      if (md == 2'd3) r = mk(M_NOP, 0, F_NONE, F_NONE, F_NONE, l3, 0);
      else begin
        m = rg == 0 ? M_PREFETCH : rg == 1 ? M_PREFETCHW : rg == 2 ? M_PREFETCHWT1 : M_NOP;
        r = mk(m, 1, F_M1632, F_NONE, F_NONE, lt, 1);
      end
    end else if (op == 8'h10 || op == 8'h11) begin
      if (rep) begin m = M_MOVSS; f = F_XMM32; end
      else if (rnz) begin m = M_MOVSD; f = F_XMM64; end
      else if (osz) begin m = M_MOVUPD; f = F_XMM128; end
      else begin m = M_MOVUPS; f = F_XMM128; end
      if (op == 8'h10) r = mk(m, 2, F_XMM, f, F_NONE, lt, 1);
      else r = mk(m, 2, f, F_XMM, F_NONE, lt, 1);
    end else if (op == 8'h12) begin
      if (rep) r = mk(M_MOVSLDUP, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
      else if (rnz) r = mk(M_MOVDDUP, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
      else if (osz) r = mk(M_MOVLPD, 2, F_XMM, F_M64, F_NONE, lt, 1);
      else r = mk(md == 2'd3 ? M_MOVHLPS : M_MOVLPS, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
    end else if (op == 8'h13) begin
      r = mk(osz ? M_MOVLPD : M_MOVLPS, 2, F_M64, F_XMM, F_NONE, lt, 1);
    end else if (op == 8'h14) begin
      if (osz) r = mk(M_UNPCKLPD, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
      else r = mk(M_UNPCKLPS, 2, F_XMM, F_XMM128, F_NONE, lt, 1);
    end else if (op == 8'h15) begin
      if (osz) r = mk(M_UNPCKHPD, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
      else r = mk(M_UNPCKHPS, 2, F_XMM, F_XMM128, F_NONE, lt, 1);
    end else if (op == 8'h16) begin
      if (rep) r = mk(M_MOVSHDUP, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
      else if (osz) r = mk(M_MOVHPD, 2, F_XMM, F_M64, F_NONE, lt, 1);
      else r = mk(md == 2'd3 ? M_MOVLHPS : M_MOVHPS, 2, F_XMM, F_XMM64, F_NONE, lt, 1);
    end else if (op == 8'h17) begin
      r = mk(osz ? M_MOVHPD : M_MOVHPS, 2, F_M64, F_XMM, F_NONE, lt, 1);
    end else if (op == 8'h18) begin
      if (md != 2'd3 && rg < 4)
        r = mk(7'(M_PREFETCHNTA) + 7'(rg), 1, F_M8, F_NONE, F_NONE, lt, 1);
      else r = mk(M_NOP, 1, F_RM1632, F_NONE, F_NONE, lt, 1);
    end else if (op >= 8'h19 && op <= 8'h1f) begin
      r = mk(M_NOP, 1, F_RM1632, F_NONE, F_NONE, lt, 1);
    end else if (op[7:4] == 4'h4) begin
      r = mk(7'(M_CMOV_BASE) + 7'(op[3:0]), 2, F_R163264, F_RM163264, F_NONE, lt, 1);
    end else if (op[7:4] == 4'h9) begin
      r = mk(7'(M_CMOV_BASE) + 7'd16 + 7'(op[3:0]), 1, F_RM8, F_NONE, F_NONE, lt, 1);
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want, logic [23:0] src);
    $display("mismatch %s: got %0d want %0d (word %h)", what, got, want, src);
    fail_count++;
  endtask

  logic [23:0] src_q[$];

  // capture accepted inputs and compare accepted results
  always @(posedge clk) begin
    cls_t       e;
    logic [23:0] s;
    if (!rst_n) begin
      want_q.delete();
      src_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          report("unexpected word", out_tdata, 0, 24'd0);
        end else begin
          e = want_q.pop_front();
          s = src_q.pop_front();
          if (out_tdata[0] !== (e.mn != 0)) report("valid_res", out_tdata[0], e.mn != 0, s);
          if (out_tdata[7:1] !== e.mn) report("mnemonic", out_tdata[7:1], e.mn, s);
          if (out_tdata[9:8] !== e.cnt) report("operand_count", out_tdata[9:8], e.cnt, s);
          if (out_tdata[14:10] !== e.fa) report("operand_form_a", out_tdata[14:10], e.fa, s);
          if (out_tdata[19:15] !== e.fb) report("operand_form_b", out_tdata[19:15], e.fb, s);
          if (out_tdata[24:20] !== e.fc) report("operand_form_c", out_tdata[24:20], e.fc, s);
          if (out_tdata[29:25] !== e.len) report("direct_length", out_tdata[29:25], e.len, s);
          if (out_tdata[30] !== e.tail) report("modrm_tail", out_tdata[30], e.tail, s);
        end
      end
      if (in_tvalid && in_tready) begin
        want_q.push_back(classify(in_tdata));
        src_q.push_back(in_tdata);
      end
    end
    pending = want_q.size();
  end

  // leftover expectations are checked by the top through pending
endmodule

### test/tb_x86_two_byte_opcode_classify.sv
// testbench top: clock, reset, stimulus, stall pattern and verdict
module tb_x86_two_byte_opcode_classify;
  import x86tbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  int          fail_count;
  int          pending;
  logic        stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  x86_two_byte_opcode_classify u_top (.*);

  x86tbc_checker u_chk (.*);

  // pack one opcode word
  function automatic logic [23:0] pack(logic [7:0] op, logic [7:0] mrm, logic [2:0] pfx,
                                       logic [3:0] cnt);
    return {1'b0, cnt, pfx, mrm, op};
  endfunction

  // drive one word, with the valid held until accepted
  task automatic send(logic [23:0] w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // pick an opcode mostly from the decoded ranges
  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1, 2: return 8'($urandom_range(0, 1));
      3: return 8'($urandom_range(2, 13));
      4, 5: return 8'($urandom_range(16, 23));
      6: return 8'($urandom_range(24, 31));
      7: return {4'h4, 4'($urandom)};
      8: return {4'h9, 4'($urandom)};
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  // receiver stall pattern
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(negedge clk);
      ph++;
      if (ph % 300 < 80) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    int burst;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: groups, special register forms, prefixes, extremes
    send(pack(8'h00, 8'h00, 3'b000, 4'd0));
    send(pack(8'h00, 8'h38, 3'b000, 4'd14));
    send(pack(8'h01, 8'hC8, 3'b000, 4'd1));
    send(pack(8'h01, 8'hC9, 3'b000, 4'd2));
    send(pack(8'h01, 8'hCA, 3'b000, 4'd0));
    send(pack(8'h01, 8'hDF, 3'b000, 4'd3));
    send(pack(8'h01, 8'hF8, 3'b000, 4'd0));
    send(pack(8'h01, 8'h3F, 3'b000, 4'd0));
    send(pack(8'h01, 8'h20, 3'b000, 4'd0));
    send(pack(8'h01, 8'hF0, 3'b000, 4'd0));
    send(pack(8'h01, 8'h28, 3'b000, 4'd0));
    send(pack(8'h0D, 8'hC0, 3'b000, 4'd4));
    send(pack(8'h0D, 8'h18, 3'b000, 4'd0));
    send(pack(8'h10, 8'h00, 3'b111, 4'd0));
    send(pack(8'h11, 8'h00, 3'b110, 4'd0));
    send(pack(8'h11, 8'h00, 3'b100, 4'd0));
    send(pack(8'h12, 8'hC0, 3'b000, 4'd0));
    send(pack(8'h16, 8'hC0, 3'b000, 4'd0));
    send(pack(8'h18, 8'h18, 3'b000, 4'd0));
    send(pack(8'h18, 8'hD8, 3'b000, 4'd0));
    send(pack(8'h04, 8'hFF, 3'b111, 4'd15));
    send(pack(8'hFF, 8'hFF, 3'b111, 4'd14));
    send(pack(8'h4F, 8'h00, 3'b000, 4'd0));
    send(pack(8'h9F, 8'h00, 3'b000, 4'd0));
    send(pack(8'h0b, 8'h00, 3'b000, 4'd7));
    // drain fully once before the random part
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // random bursts
    for (int i = 0; i < 400; ) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && i < 400; j++, i++)
        send(pack(pick_op(), 8'($urandom), 3'($urandom), 4'($urandom_range(0, 15))));
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // verdict
  initial begin
    wait (stim_done);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
